/* design/tmco_pkg.sv */
`timescale 1ns / 1ps
package tmco_pkg;

  localparam int AREA_W = 24;
  localparam int SUM_W = 36;
  localparam int OUT_W = 12;
  localparam int LANES = 6;

  localparam int COORD_INT_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF = 8;

  typedef logic [AREA_W-1:0] area_t;
  typedef logic [SUM_W-1:0] sum_t;
  typedef logic [OUT_W-1:0] pix_t;

endpackage

/* design/three_marker_centroid_order_core.sv */
`timescale 1ns / 1ps
// Three-marker centroid ordering core.
// The input channel (in_valid / in_ready) takes one request holding the area and the x and y
// first moments of three blobs. Each request gives exactly one result on the output channel
// (out_valid / out_ready): the origin centroid and the other two centroids in cross-product
// order, all in whole pixels, with status set when any area is zero (points then read zero).
// From acceptance a request passes through the restoring divider, which resolves one
// quotient bit per stage for all six coordinates in parallel, then through the square,
// score, select, cross product and output stages. A new request is taken in every cycle
// while the output is free or being taken.
// The whole pipeline advances together: while out_valid is high and out_ready low, every
// stage holds and in_ready is low, so nothing is lost or repeated. Valid bits travel with
// the data through every stage.
// Synchronous reset clears all valid bits; payload registers are not reset.
module three_marker_centroid_order_core #(
  parameter int COORD_INT_BITS = tmco_pkg::COORD_INT_BITS_DEF,
  parameter int FRAC_BITS = tmco_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tmco_pkg::area_t   in_area_first,
  input  tmco_pkg::sum_t    in_xsum_first,
  input  tmco_pkg::sum_t    in_ysum_first,
  input  tmco_pkg::area_t   in_area_second,
  input  tmco_pkg::sum_t    in_xsum_second,
  input  tmco_pkg::sum_t    in_ysum_second,
  input  tmco_pkg::area_t   in_area_third,
  input  tmco_pkg::sum_t    in_xsum_third,
  input  tmco_pkg::sum_t    in_ysum_third,
  output logic              out_valid,
  input  logic              out_ready,
  output tmco_pkg::pix_t    out_origin_x,
  output tmco_pkg::pix_t    out_origin_y,
  output tmco_pkg::pix_t    out_next_x,
  output tmco_pkg::pix_t    out_next_y,
  output tmco_pkg::pix_t    out_last_x,
  output tmco_pkg::pix_t    out_last_y,
  output logic              out_status
);
  import tmco_pkg::*;

  localparam int CW = COORD_INT_BITS + FRAC_BITS;
  localparam int NW = SUM_W + FRAC_BITS;
  localparam int HW = NW - CW;
  localparam int EXT = HW + AREA_W;
  localparam int SQ_W = 2 * CW;
  localparam int SC_W = SQ_W + 2;
  localparam int PR_W = 2 * CW + 2;
  localparam int PX_W = CW + OUT_W;

  logic adv;
  assign adv = !out_valid || out_ready;
  assign in_ready = adv;

  // Divider pipeline: stage 0 holds the prepared operands, stage s resolves quotient bit CW-s.
  logic [NW-1:0]     dnum_r  [0:CW][0:LANES-1];
  logic [AREA_W-1:0] drem_r  [0:CW][0:LANES-1];
  logic [CW-1:0]     dq_r    [0:CW][0:LANES-1];
  logic [AREA_W-1:0] darea_r [0:CW][0:LANES-1];
  logic              dsat_r  [0:CW][0:LANES-1];
  logic [CW:0]       dvalid_r;
  logic [CW:0]       dzero_r;

  sum_t  in_sum [0:LANES-1];
  area_t in_area [0:LANES-1];
  logic  [NW-1:0] in_num [0:LANES-1];
  logic  [HW-1:0] in_hi [0:LANES-1];
  logic  in_sat [0:LANES-1];

  always_comb begin
    in_sum[0] = in_xsum_first;
    in_sum[1] = in_ysum_first;
    in_sum[2] = in_xsum_second;
    in_sum[3] = in_ysum_second;
    in_sum[4] = in_xsum_third;
    in_sum[5] = in_ysum_third;
    in_area[0] = in_area_first;
    in_area[1] = in_area_first;
    in_area[2] = in_area_second;
    in_area[3] = in_area_second;
    in_area[4] = in_area_third;
    in_area[5] = in_area_third;
    for (int l = 0; l < LANES; l++) begin
      in_num[l] = NW'(in_sum[l]) << FRAC_BITS;
      in_hi[l] = in_num[l][NW-1:CW];
      // A quotient wider than CW bits saturates.
      in_sat[l] = EXT'(in_hi[l]) >= EXT'(in_area[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < LANES; l++) begin
        dnum_r[0][l] <= in_num[l];
        darea_r[0][l] <= in_area[l];
        dsat_r[0][l] <= in_sat[l];
        drem_r[0][l] <= AREA_W'(in_hi[l]);
        dq_r[0][l] <= '0;
      end
      dzero_r[0] <= (in_area_first == '0) || (in_area_second == '0) ||
                    (in_area_third == '0);
      for (int s = 1; s <= CW; s++) begin
        for (int l = 0; l < LANES; l++) begin
          logic [AREA_W:0] t;
          t = {drem_r[s-1][l], dnum_r[s-1][l][CW-s]};
          if (t >= {1'b0, darea_r[s-1][l]}) begin
            drem_r[s][l] <= AREA_W'(t - {1'b0, darea_r[s-1][l]});
            dq_r[s][l] <= dq_r[s-1][l] | (CW'(1) << (CW - s));
          end else begin
            drem_r[s][l] <= t[AREA_W-1:0];
            dq_r[s][l] <= dq_r[s-1][l];
          end
          dnum_r[s][l] <= dnum_r[s-1][l];
          darea_r[s][l] <= darea_r[s-1][l];
          dsat_r[s][l] <= dsat_r[s-1][l];
        end
        dzero_r[s] <= dzero_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dvalid_r <= '0;
    end else if (adv) begin
      dvalid_r <= {dvalid_r[CW-1:0], in_valid};
    end
  end

  // Stage E1: centroids and squared pair differences.
  logic [CW-1:0] cen [0:LANES-1];
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      cen[l] = dsat_r[CW][l] ? {CW{1'b1}} : dq_r[CW][l];
    end
  end

  function automatic logic [SQ_W-1:0] sq_diff(input logic [CW-1:0] p, input logic [CW-1:0] q);
    logic [CW-1:0] m;
    m = (p >= q) ? p - q : q - p;
    return SQ_W'(m) * SQ_W'(m);
  endfunction

  logic [CW-1:0]   e1_cen_r [0:LANES-1];
  logic [SQ_W-1:0] e1_sq_r [0:LANES-1];
  logic            e1_valid_r, e1_zero_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < LANES; l++) e1_cen_r[l] <= cen[l];
      e1_sq_r[0] <= sq_diff(cen[0], cen[2]);
      e1_sq_r[1] <= sq_diff(cen[1], cen[3]);
      e1_sq_r[2] <= sq_diff(cen[0], cen[4]);
      e1_sq_r[3] <= sq_diff(cen[1], cen[5]);
      e1_sq_r[4] <= sq_diff(cen[2], cen[4]);
      e1_sq_r[5] <= sq_diff(cen[3], cen[5]);
      e1_zero_r <= dzero_r[CW];
    end
  end

  // Stage E2: scores.
  logic [SC_W-1:0] d01, d02, d12;
  assign d01 = SC_W'(e1_sq_r[0]) + SC_W'(e1_sq_r[1]);
  assign d02 = SC_W'(e1_sq_r[2]) + SC_W'(e1_sq_r[3]);
  assign d12 = SC_W'(e1_sq_r[4]) + SC_W'(e1_sq_r[5]);

  logic [CW-1:0]   e2_cen_r [0:LANES-1];
  logic [SC_W-1:0] e2_sc_r [0:2];
  logic            e2_valid_r, e2_zero_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < LANES; l++) e2_cen_r[l] <= e1_cen_r[l];
      e2_sc_r[0] <= d01 + d02;
      e2_sc_r[1] <= d01 + d12;
      e2_sc_r[2] <= d02 + d12;
      e2_zero_r <= e1_zero_r;
    end
  end

  // Stage E3: origin choice and edge vectors. Ties keep the lower blob.
  logic [1:0] org, ia, ib;
  always_comb begin
    logic [SC_W-1:0] best;
    org = 2'd0;
    best = e2_sc_r[0];
    if (e2_sc_r[1] < best) begin
      org = 2'd1;
      best = e2_sc_r[1];
    end
    if (e2_sc_r[2] < best) begin
      org = 2'd2;
    end
    ia = (org == 2'd0) ? 2'd1 : 2'd0;
    ib = (org == 2'd2) ? 2'd1 : 2'd2;
  end

  logic [CW-1:0] ox, oy, ax, ay, bx, by;
  always_comb begin
    ox = e2_cen_r[{org, 1'b0}];
    oy = e2_cen_r[{org, 1'b1}];
    ax = e2_cen_r[{ia, 1'b0}];
    ay = e2_cen_r[{ia, 1'b1}];
    bx = e2_cen_r[{ib, 1'b0}];
    by = e2_cen_r[{ib, 1'b1}];
  end

  logic [CW-1:0]        e3_o_r [0:1];
  logic [CW-1:0]        e3_a_r [0:1];
  logic [CW-1:0]        e3_b_r [0:1];
  logic signed [CW:0]   e3_v_r [0:3];
  logic                 e3_valid_r, e3_zero_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      e3_o_r[0] <= ox;
      e3_o_r[1] <= oy;
      e3_a_r[0] <= ax;
      e3_a_r[1] <= ay;
      e3_b_r[0] <= bx;
      e3_b_r[1] <= by;
      e3_v_r[0] <= signed'({1'b0, ax}) - signed'({1'b0, ox});
      e3_v_r[1] <= signed'({1'b0, ay}) - signed'({1'b0, oy});
      e3_v_r[2] <= signed'({1'b0, bx}) - signed'({1'b0, ox});
      e3_v_r[3] <= signed'({1'b0, by}) - signed'({1'b0, oy});
      e3_zero_r <= e2_zero_r;
    end
  end

  // Stage E4: the two cross-product terms.
  logic [CW-1:0]        e4_o_r [0:1];
  logic [CW-1:0]        e4_a_r [0:1];
  logic [CW-1:0]        e4_b_r [0:1];
  logic signed [PR_W-1:0] e4_p1_r, e4_p0_r;
  logic                 e4_valid_r, e4_zero_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      e4_o_r <= e3_o_r;
      e4_a_r <= e3_a_r;
      e4_b_r <= e3_b_r;
      e4_p1_r <= PR_W'(e3_v_r[2] * e3_v_r[1]);
      e4_p0_r <= PR_W'(e3_v_r[0] * e3_v_r[3]);
      e4_zero_r <= e3_zero_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_valid_r <= 1'b0;
      e2_valid_r <= 1'b0;
      e3_valid_r <= 1'b0;
      e4_valid_r <= 1'b0;
    end else if (adv) begin
      e1_valid_r <= dvalid_r[CW];
      e2_valid_r <= e1_valid_r;
      e3_valid_r <= e2_valid_r;
      e4_valid_r <= e3_valid_r;
    end
  end

  // Output stage.
  function automatic pix_t to_pix(input logic [CW-1:0] c);
    logic [PX_W-1:0] t;
    t = PX_W'(c) >> FRAC_BITS;
    return t[OUT_W-1:0];
  endfunction

  logic cross_nonneg;
  assign cross_nonneg = e4_p1_r >= e4_p0_r;

  pix_t origin_x_r, origin_y_r, next_x_r, next_y_r, last_x_r, last_y_r;
  logic status_r, out_valid_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      status_r <= e4_zero_r;
      if (e4_zero_r) begin
        origin_x_r <= '0;
        origin_y_r <= '0;
        next_x_r <= '0;
        next_y_r <= '0;
        last_x_r <= '0;
        last_y_r <= '0;
      end else begin
        origin_x_r <= to_pix(e4_o_r[0]);
        origin_y_r <= to_pix(e4_o_r[1]);
        if (cross_nonneg) begin
          next_x_r <= to_pix(e4_b_r[0]);
          next_y_r <= to_pix(e4_b_r[1]);
          last_x_r <= to_pix(e4_a_r[0]);
          last_y_r <= to_pix(e4_a_r[1]);
        end else begin
          next_x_r <= to_pix(e4_a_r[0]);
          next_y_r <= to_pix(e4_a_r[1]);
          last_x_r <= to_pix(e4_b_r[0]);
          last_y_r <= to_pix(e4_b_r[1]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= e4_valid_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_origin_x = origin_x_r;
  assign out_origin_y = origin_y_r;
  assign out_next_x = next_x_r;
  assign out_next_y = next_y_r;
  assign out_last_x = last_x_r;
  assign out_last_y = last_y_r;
  assign out_status = status_r;

endmodule

/* test/tb_three_marker_centroid_order_core.sv */
`timescale 1ns / 1ps
module tb_three_marker_centroid_order_core;
  import tmco_pkg::*;

  localparam int CI_BITS = COORD_INT_BITS_DEF;
  localparam int FR_BITS = FRAC_BITS_DEF;
  localparam longint unsigned CMAX = (64'd1 << (CI_BITS + FR_BITS)) - 1;

  typedef struct packed {
    area_t area;
    sum_t  xsum;
    sum_t  ysum;
  } blob_t;

  typedef struct packed {
    pix_t ox, oy, nx, ny, lx, ly;
    logic st;
  } points_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  area_t in_area_first = '0, in_area_second = '0, in_area_third = '0;
  sum_t in_xsum_first = '0, in_ysum_first = '0, in_xsum_second = '0;
  sum_t in_ysum_second = '0, in_xsum_third = '0, in_ysum_third = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  pix_t out_origin_x, out_origin_y, out_next_x, out_next_y, out_last_x, out_last_y;
  logic out_status;

  points_t pending_points[$];
  int errors = 0;
  int ready_gap = 0;
  bit stall_enable = 1'b0;
  bit idle_enable = 1'b0;
  bit hold_off = 1'b0;

  always #6 clk = ~clk;

  three_marker_centroid_order_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_area_first(in_area_first), .in_xsum_first(in_xsum_first),
    .in_ysum_first(in_ysum_first),
    .in_area_second(in_area_second), .in_xsum_second(in_xsum_second),
    .in_ysum_second(in_ysum_second),
    .in_area_third(in_area_third), .in_xsum_third(in_xsum_third),
    .in_ysum_third(in_ysum_third),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_origin_x(out_origin_x), .out_origin_y(out_origin_y),
    .out_next_x(out_next_x), .out_next_y(out_next_y),
    .out_last_x(out_last_x), .out_last_y(out_last_y),
    .out_status(out_status)
  );

  function automatic longint centroid(sum_t s, area_t a);
    longint unsigned q;
    q = ({28'd0, s} << FR_BITS) / {40'd0, a};
    return (q > CMAX) ? longint'(CMAX) : longint'(q);
  endfunction

  function automatic pix_t to_pix(longint c);
    return pix_t'(c >> FR_BITS);
  endfunction

  function automatic points_t order_markers(blob_t b0, blob_t b1, blob_t b2);
    points_t r;
    blob_t bl[3];
    longint cx[3], cy[3];
    longint unsigned score[3], best;
    longint vx0, vy0, vx1, vy1, cprod;
    int o, a, b, n, l;
    r = '0;
    bl[0] = b0; bl[1] = b1; bl[2] = b2;
    if (b0.area == 0 || b1.area == 0 || b2.area == 0) begin
      r.st = 1'b1;
      return r;
    end
    for (int i = 0; i < 3; i++) begin
      cx[i] = centroid(bl[i].xsum, bl[i].area);
      cy[i] = centroid(bl[i].ysum, bl[i].area);
    end
    for (int i = 0; i < 3; i++) begin
      score[i] = 0;
      for (int j = 0; j < 3; j++)
        if (j != i)
          score[i] += (cx[i] - cx[j]) * (cx[i] - cx[j]) + (cy[i] - cy[j]) * (cy[i] - cy[j]);
    end
    o = 0;
    best = score[0];
    for (int i = 1; i < 3; i++)
      if (score[i] < best) begin
        best = score[i];
        o = i;
      end
    a = (o == 0) ? 1 : 0;
    b = (o == 2) ? 1 : 2;
    vx0 = cx[a] - cx[o]; vy0 = cy[a] - cy[o];
    vx1 = cx[b] - cx[o]; vy1 = cy[b] - cy[o];
    cprod = vx1 * vy0 - vx0 * vy1;
    n = (cprod >= 0) ? b : a;
    l = (cprod >= 0) ? a : b;
    r.ox = to_pix(cx[o]); r.oy = to_pix(cy[o]);
    r.nx = to_pix(cx[n]); r.ny = to_pix(cy[n]);
    r.lx = to_pix(cx[l]); r.ly = to_pix(cy[l]);
    return r;
  endfunction

  // Valid stays high when the next request follows at once; it is lowered before any idling.
  task automatic send_blobs(blob_t b0, blob_t b1, blob_t b2);
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_area_first <= b0.area; in_xsum_first <= b0.xsum; in_ysum_first <= b0.ysum;
    in_area_second <= b1.area; in_xsum_second <= b1.xsum; in_ysum_second <= b1.ysum;
    in_area_third <= b2.area; in_xsum_third <= b2.xsum; in_ysum_third <= b2.ysum;
    pending_points.insert(pending_points.size(), order_markers(b0, b1, b2));
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Places a blob with centroid near (x, y) pixels and a random area.
  function automatic blob_t blob_at(int x, int y);
    blob_t b;
    b.area = area_t'($urandom_range(1, 4000));
    b.xsum = sum_t'((longint'(x) * b.area) + $urandom_range(0, b.area - 1));
    b.ysum = sum_t'((longint'(y) * b.area) + $urandom_range(0, b.area - 1));
    return b;
  endfunction

  function automatic blob_t blob_rand();
    blob_t b;
    b.area = area_t'({$urandom, $urandom});
    b.xsum = sum_t'({$urandom, $urandom});
    b.ysum = sum_t'({$urandom, $urandom});
    if ($urandom_range(0, 3) == 0) b.area = area_t'($urandom_range(1, 255));
    return b;
  endfunction

  task automatic test_directed();
    blob_t z, mx, one;
    z = '0;
    mx = '1;
    one = '{area: 24'd1, xsum: 36'd0, ysum: 36'd0};
    send_blobs(z, z, z);
    send_blobs(z, mx, mx);
    send_blobs(mx, z, mx);
    send_blobs(mx, mx, z);
    send_blobs(mx, mx, mx);
    send_blobs(one, one, one);
    send_blobs(one, mx, '{area: 24'd1, xsum: 36'd5, ysum: 36'd0});
    send_blobs('{area: 24'h800000, xsum: '1, ysum: 36'd0}, mx, one);
    send_blobs(blob_at(0, 0), blob_at(100, 0), blob_at(0, 100));
    send_blobs(blob_at(0, 0), blob_at(0, 100), blob_at(100, 0));
    send_blobs(blob_at(100, 0), blob_at(0, 0), blob_at(0, 100));
    send_blobs(blob_at(100, 0), blob_at(0, 100), blob_at(0, 0));
    send_blobs(blob_at(10, 10), blob_at(20, 20), blob_at(30, 30));
    send_blobs(blob_at(4095, 4095), blob_at(0, 4095), blob_at(4095, 0));
    // Collinear points put the middle blob at the origin; identical points tie all
    // three scores, so the lowest blob wins.
    send_blobs('{area: 1, xsum: 0, ysum: 0}, '{area: 1, xsum: 2, ysum: 0},
               '{area: 1, xsum: 1, ysum: 0});
    send_blobs('{area: 1, xsum: 0, ysum: 0}, '{area: 1, xsum: 0, ysum: 0},
               '{area: 1, xsum: 0, ysum: 0});
  endtask

  task automatic test_random(int count);
    int x0, y0;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 4) == 0)
        send_blobs(blob_rand(), blob_rand(), blob_rand());
      else begin
        x0 = $urandom_range(0, 3800);
        y0 = $urandom_range(0, 3800);
        send_blobs(blob_at(x0 + $urandom_range(0, 290), y0 + $urandom_range(0, 290)),
                   blob_at(x0 + $urandom_range(0, 290), y0 + $urandom_range(0, 290)),
                   blob_at(x0 + $urandom_range(0, 290), y0 + $urandom_range(0, 290)));
      end
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
  endtask

  // The receiver holds off for a long stretch while requests keep coming.
  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin
        repeat (80) @(posedge clk);
        hold_off = 1'b0;
      end
      test_random(60);
    join
    wait_drained();
  endtask

  // Receiver stalls come in random bursts.
  always @(posedge clk) begin
    if (hold_off)
      out_ready <= 1'b0;
    else if (stall_enable && ready_gap > 0) begin
      ready_gap--;
      out_ready <= 1'b0;
    end else if (stall_enable && $urandom_range(0, 5) == 0) begin
      ready_gap = $urandom_range(0, 4);
      out_ready <= 1'b0;
    end else
      out_ready <= 1'b1;
  end

  always @(posedge clk) begin
    points_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_points.size() == 0) begin
        $error("result with nothing expected");
        errors++;
      end else begin
        e = pending_points.pop_front();
        if (out_origin_x !== e.ox) begin
          $error("origin_x exp %0d got %0d", e.ox, out_origin_x); errors++;
        end
        if (out_origin_y !== e.oy) begin
          $error("origin_y exp %0d got %0d", e.oy, out_origin_y); errors++;
        end
        if (out_next_x !== e.nx) begin
          $error("next_x exp %0d got %0d", e.nx, out_next_x); errors++;
        end
        if (out_next_y !== e.ny) begin
          $error("next_y exp %0d got %0d", e.ny, out_next_y); errors++;
        end
        if (out_last_x !== e.lx) begin
          $error("last_x exp %0d got %0d", e.lx, out_last_x); errors++;
        end
        if (out_last_y !== e.ly) begin
          $error("last_y exp %0d got %0d", e.ly, out_last_y); errors++;
        end
        if (out_status !== e.st) begin
          $error("status exp %0d got %0d", e.st, out_status); errors++;
        end
      end
    end
  end

  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    stall_enable = 1'b1;
    idle_enable = 1'b1;
    test_directed();
    wait_drained();
    test_random(300);
    test_backpressure();
    stall_enable = 1'b0;
    idle_enable = 1'b0;
    test_random(250);
    wait_drained();
    repeat (40) @(posedge clk);
    if (errors == 0 && pending_points.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
